// ===== rtl/swal_pkg.sv =====
// ----------------------------------------------------------------------------
// swal_pkg
// Shared types and constants for the sliding window access log.
// ----------------------------------------------------------------------------
`default_nettype none

package swal_pkg;

    localparam int DEFAULT_LOG_DEPTH  = 128;
    localparam int DEFAULT_STAMP_BITS = 32;

    localparam int KEY_W    = 8;
    localparam int WINDOW_W = 16;
    localparam int RESULT_W = 8;
    localparam int ADDR_W   = 3;
    localparam int DATA_W   = 32;
    localparam int CHUNK_W  = 8;

    localparam logic [WINDOW_W-1:0] WINDOW_RESET = 16'd7;

    // register index taken from paddr[ADDR_W-1:2]
    localparam logic [ADDR_W-3:0] REG_WINDOW = 1'b0;

    localparam logic OP_RECORD = 1'b0;
    localparam logic OP_QUERY  = 1'b1;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXPIRE,
        S_COUNT
    } t_state;

    // per-cell control: shift toward the oldest end, and/or take the new entry
    typedef struct packed {
        logic shift;
        logic load;
    } t_cell_ctl;

endpackage

`default_nettype wire

// ===== rtl/swal_cell.sv =====
// ----------------------------------------------------------------------------
// swal_cell
// One entry of the access log: valid flag, key and stamp, shifting toward
// the oldest end and comparing its key against the queried key.
// ----------------------------------------------------------------------------
`default_nettype none

module swal_cell #(
    parameter int STAMP_BITS = swal_pkg::DEFAULT_STAMP_BITS
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire swal_pkg::t_cell_ctl        i_ctl,
    input  wire logic                       i_next_valid,
    input  wire logic [swal_pkg::KEY_W-1:0] i_next_key,
    input  wire logic [STAMP_BITS-1:0]      i_next_stamp,
    input  wire logic [swal_pkg::KEY_W-1:0] i_new_key,
    input  wire logic [STAMP_BITS-1:0]      i_new_stamp,
    input  wire logic [swal_pkg::KEY_W-1:0] i_query_key,
    output logic                            o_valid,
    output logic [swal_pkg::KEY_W-1:0]      o_key,
    output logic [STAMP_BITS-1:0]           o_stamp,
    output logic                            o_match
);
    import swal_pkg::*;

    logic                  r_valid;
    logic [KEY_W-1:0]      r_key;
    logic [STAMP_BITS-1:0] r_stamp;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_ctl.load) begin
            r_valid <= 1'b1;
        end else if (i_ctl.shift) begin
            r_valid <= i_next_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_key   <= i_new_key;
            r_stamp <= i_new_stamp;
        end else if (i_ctl.shift) begin
            r_key   <= i_next_key;
            r_stamp <= i_next_stamp;
        end
    end

    assign o_valid = r_valid;
    assign o_key   = r_key;
    assign o_stamp = r_stamp;
    assign o_match = r_valid && (r_key == i_query_key);

endmodule

`default_nettype wire

// ===== rtl/sliding_window_access_log.sv =====
// ----------------------------------------------------------------------------
// sliding_window_access_log
// Time-ordered log of recent accesses with window expiry and key counting.
// ----------------------------------------------------------------------------
// Usage
//   Input: raise start with i_operation, i_access_key and i_stamp; the
//   transaction is taken when start is high and busy is low. Busy stays high
//   until the result is shown.
//   Output: one result per transaction, held for exactly one cycle while
//   o_result_valid is high. The receiver cannot stall the block.
//   Configuration: APB register 0 (byte address 0) holds the 16-bit window
//   length, reset to 7; write it only while busy is low.
// Timing
//   Entries live in a row of cells, oldest at cell 0. Expiry checks cell 0
//   and shifts the row by one per cycle while cell 0 holds an expired entry.
//   Record: the strobe rises at the edge that leaves the expiry state, and busy
//   drops at that same edge.
//   Query: after expiry, the match bits are summed 8 cells per cycle, and the
//   strobe rises at the edge that ends the last chunk of the sum. A new
//   transaction can be taken in the cycle the strobe is shown.
// Reset
//   Synchronous reset empties the log and restores the window length.
// ----------------------------------------------------------------------------
`default_nettype none

module sliding_window_access_log #(
    parameter int LOG_DEPTH  = swal_pkg::DEFAULT_LOG_DEPTH,
    parameter int STAMP_BITS = swal_pkg::DEFAULT_STAMP_BITS
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    // command channel
    input  wire logic                          start,
    output logic                               busy,
    input  wire logic                          i_operation,
    input  wire logic [swal_pkg::KEY_W-1:0]    i_access_key,
    input  wire logic [STAMP_BITS-1:0]         i_stamp,
    // result channel
    output logic                               o_result_valid,
    output logic [swal_pkg::RESULT_W-1:0]      o_match_count,
    output logic                               o_key_seen,
    output logic                               o_oldest_dropped,
    output logic [swal_pkg::RESULT_W-1:0]      o_occupancy,
    // configuration
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [swal_pkg::ADDR_W-1:0]   paddr,
    input  wire logic [swal_pkg::DATA_W-1:0]   pwdata,
    output logic [swal_pkg::DATA_W-1:0]        prdata,
    output logic                               pready
);
    import swal_pkg::*;

    localparam int CNT_W       = $clog2(LOG_DEPTH + 1);
    localparam int CMP_W       = (STAMP_BITS > WINDOW_W) ? STAMP_BITS : WINDOW_W;
    localparam int NCHUNK      = (LOG_DEPTH + CHUNK_W - 1) / CHUNK_W;
    localparam int CHUNK_IDX_W = (NCHUNK > 1) ? $clog2(NCHUNK) : 1;

    t_state                 r_state;
    t_state                 n_state;
    logic                   r_op;
    logic [KEY_W-1:0]       r_key;
    logic [STAMP_BITS-1:0]  r_stamp;
    logic [CMP_W-1:0]       r_limit;
    logic                   r_early;
    logic [CNT_W-1:0]       r_count;
    logic [CNT_W-1:0]       n_count;
    logic [CHUNK_IDX_W-1:0] r_chunk;
    logic [CNT_W-1:0]       r_acc;
    logic [WINDOW_W-1:0]    r_window;

    logic                   r_out_valid;
    logic [RESULT_W-1:0]    r_match_count;
    logic                   r_key_seen;
    logic                   r_dropped;
    logic [RESULT_W-1:0]    r_occ;

    t_cell_ctl              w_ctl   [LOG_DEPTH];
    logic [LOG_DEPTH-1:0]   w_valid;
    logic [LOG_DEPTH-1:0]   w_match;
    logic [KEY_W-1:0]       w_key   [LOG_DEPTH];
    logic [STAMP_BITS-1:0]  w_stamp [LOG_DEPTH];

    logic                      w_accept;
    logic                      w_full;
    logic                      w_expire;
    logic                      w_append;
    logic                      w_shift;
    logic                      w_last_chunk;
    logic [NCHUNK*CHUNK_W-1:0] w_match_pad;
    logic [CHUNK_W-1:0]        w_chunk_bits;
    logic [CNT_W-1:0]          w_total;
    logic                      w_cfg_write;

    // ------------------------------------------------------------------
    // configuration port
    // ------------------------------------------------------------------
    assign pready      = 1'b1;
    assign w_cfg_write = psel && penable && pwrite && (paddr[ADDR_W-1:2] == REG_WINDOW);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window <= WINDOW_RESET;
        end else if (w_cfg_write) begin
            r_window <= pwdata[WINDOW_W-1:0];
        end
    end

    always_comb begin
        prdata = '0;
        if (paddr[ADDR_W-1:2] == REG_WINDOW) begin
            prdata = DATA_W'(r_window);
        end
    end

    // ------------------------------------------------------------------
    // cell row, oldest entry in cell 0
    // ------------------------------------------------------------------
    for (genvar g = 0; g < LOG_DEPTH; g++) begin : g_cell
        logic                  w_nv;
        logic [KEY_W-1:0]      w_nk;
        logic [STAMP_BITS-1:0] w_ns;

        if (g == LOG_DEPTH - 1) begin : g_tail
            assign w_nv = 1'b0;
            assign w_nk = '0;
            assign w_ns = '0;
        end else begin : g_body
            assign w_nv = w_valid[g+1];
            assign w_nk = w_key[g+1];
            assign w_ns = w_stamp[g+1];
        end

        swal_cell #(
            .STAMP_BITS (STAMP_BITS)
        ) u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_ctl        (w_ctl[g]),
            .i_next_valid (w_nv),
            .i_next_key   (w_nk),
            .i_next_stamp (w_ns),
            .i_new_key    (r_key),
            .i_new_stamp  (r_stamp),
            .i_query_key  (r_key),
            .o_valid      (w_valid[g]),
            .o_key        (w_key[g]),
            .o_stamp      (w_stamp[g]),
            .o_match      (w_match[g])
        );
    end

    // ------------------------------------------------------------------
    // control
    // ------------------------------------------------------------------
    assign busy     = (r_state != S_IDLE);
    assign w_accept = start && !busy;
    assign w_full   = (r_count == CNT_W'(LOG_DEPTH));

    // oldest entry stamped at or before now - window goes away
    assign w_expire = (r_state == S_EXPIRE) && w_valid[0] && !r_early
                      && (CMP_W'(w_stamp[0]) <= r_limit);
    assign w_append = (r_state == S_EXPIRE) && !w_expire && (r_op == OP_RECORD);
    assign w_shift  = w_expire || (w_append && w_full);

    assign w_match_pad  = (NCHUNK*CHUNK_W)'(w_match);
    assign w_chunk_bits = w_match_pad[r_chunk*CHUNK_W +: CHUNK_W];
    assign w_total      = r_acc + CNT_W'($countones(w_chunk_bits));
    assign w_last_chunk = (r_chunk == CHUNK_IDX_W'(NCHUNK - 1));

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_state = S_EXPIRE;
                end
            end
            S_EXPIRE: begin
                if (!w_expire) begin
                    n_state = (r_op == OP_RECORD) ? S_IDLE : S_COUNT;
                end
            end
            S_COUNT: begin
                if (w_last_chunk) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // cell controls and fill count
    always_comb begin
        n_count = r_count;
        if (w_expire) begin
            n_count = r_count - CNT_W'(1);
        end else if (w_append && !w_full) begin
            n_count = r_count + CNT_W'(1);
        end
        for (int i = 0; i < LOG_DEPTH; i++) begin
            w_ctl[i].shift = w_shift;
            w_ctl[i].load  = w_append && (w_full ? (i == LOG_DEPTH - 1)
                                                 : (r_count == CNT_W'(i)));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_op    <= i_operation;
            r_key   <= i_access_key;
            r_stamp <= i_stamp;
            r_limit <= CMP_W'(i_stamp) - CMP_W'(r_window);
            r_early <= CMP_W'(i_stamp) < CMP_W'(r_window);
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_EXPIRE) begin
            r_chunk <= '0;
            r_acc   <= '0;
        end else if (r_state == S_COUNT) begin
            r_chunk <= r_chunk + CHUNK_IDX_W'(1);
            r_acc   <= w_total;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= w_append || ((r_state == S_COUNT) && w_last_chunk);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_append) begin
            r_match_count <= '0;
            r_key_seen    <= 1'b0;
            r_dropped     <= w_full;
            r_occ         <= RESULT_W'(n_count);
        end else if ((r_state == S_COUNT) && w_last_chunk) begin
            r_match_count <= RESULT_W'(w_total);
            r_key_seen    <= (w_total != '0);
            r_dropped     <= 1'b0;
            r_occ         <= RESULT_W'(r_count);
        end
    end

    assign o_result_valid   = r_out_valid;
    assign o_match_count    = r_match_count;
    assign o_key_seen       = r_key_seen;
    assign o_oldest_dropped = r_dropped;
    assign o_occupancy      = r_occ;

    // ------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------
    a_valid_matches_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones(w_valid) == r_count)
        else $error("cell valid bits disagree with fill count");

    a_count_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(LOG_DEPTH))
        else $error("fill count above depth");

    a_result_when_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_state == S_IDLE))
        else $error("result shown while a transaction is still in flight");

    a_accept_goes_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> busy && !r_out_valid)
        else $error("accepted transaction did not start work");

    a_record_no_matches: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_op == OP_RECORD)) |-> (r_match_count == '0) && !r_key_seen)
        else $error("record transaction reported matches");

endmodule

`default_nettype wire
